// File: rtl/circ_pkg.sv
`default_nettype none
package circ_pkg;

	localparam int NUM_W  = 100;
	localparam int DEN_W  = 68;
	localparam int REM_W  = 101;
	localparam int ROOT_W = 32;
	localparam int SRAD_W = 64;
	localparam int SREM_W = 36;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_DEGEN = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by_coord;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} pts_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [31:0] radius;
		logic        [1:0]  status;
	} circ_t;

	typedef struct packed {
		logic [NUM_W-1:0]   nx_abs;
		logic [NUM_W-1:0]   ny_abs;
		logic [DEN_W-1:0]   d_abs;
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               coll;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
	} div_in_t;

	typedef struct packed {
		logic [31:0]        qx;
		logic [31:0]        qy;
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               coll;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
	} div_out_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic               coll;
		logic               sat;
		logic               big;
	} sq_tag_t;

endpackage
`default_nettype wire

// File: rtl/circ_front.sv
`default_nettype none
module circ_front #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              src_valid,
	input  circ_pkg::pts_t    src,
	input  logic [31:0]       thr,
	output logic              dst_valid,
	output circ_pkg::div_in_t dst
);
	import circ_pkg::*;

	function automatic logic signed [31:0] sext(input logic [31:0] r);
		return $signed(r << (32 - COORD_WIDTH)) >>> (32 - COORD_WIDTH);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [31:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [32:0] dd_s1 [0:5];

	logic signed [31:0] ax_s2, ay_s2;
	logic signed [64:0] p_s2 [0:2];
	logic        [63:0] sq_s2 [0:5];
	logic signed [32:0] dd_s2 [0:5];

	logic signed [31:0] ax_s3, ay_s3;
	logic signed [DEN_W-1:0] det_s3;
	logic        [63:0] s_s3 [0:2];
	logic signed [32:0] dd_s3 [0:5];

	logic signed [31:0] ax_s4, ay_s4;
	logic [DEN_W-1:0]   dabs_s4;
	logic               dneg_s4;
	logic signed [65:0] plo_s4 [0:5];
	logic signed [65:0] phi_s4 [0:5];

	logic signed [31:0] ax_s5, ay_s5;
	logic [DEN_W-1:0]   dabs_s5;
	logic               dneg_s5, coll_s5;
	logic [REM_W-1:0]   dsh_s5, dshp_s5;
	logic signed [NUM_W-1:0] t_s5 [0:5];

	logic signed [31:0] ax_s6, ay_s6;
	logic [DEN_W-1:0]   dabs_s6;
	logic               dneg_s6, coll_s6;
	logic [REM_W-1:0]   dsh_s6, dshp_s6;
	logic signed [NUM_W-1:0] nx_s6, ny_s6;

	logic signed [31:0] ax_s7, ay_s7;
	logic [DEN_W-1:0]   dabs_s7;
	logic               coll_s7, negx_s7, negy_s7;
	logic [REM_W-1:0]   dsh_s7, dshp_s7;
	logic [NUM_W-1:0]   nxa_s7, nya_s7;

	logic signed [31:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
	logic [DEN_W-1:0]   thr_sh;

	always_comb begin
		ax_e = sext(src.ax);
		ay_e = sext(src.ay);
		bx_e = sext(src.bx);
		by_e = sext(src.by_coord);
		cx_e = sext(src.cx);
		cy_e = sext(src.cy);
		thr_sh = DEN_W'(thr) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax_e;
			ay_s1 <= ay_e;
			bx_s1 <= bx_e;
			by_s1 <= by_e;
			cx_s1 <= cx_e;
			cy_s1 <= cy_e;
			dd_s1[0] <= {by_e[31], by_e} - {cy_e[31], cy_e};
			dd_s1[1] <= {cy_e[31], cy_e} - {ay_e[31], ay_e};
			dd_s1[2] <= {ay_e[31], ay_e} - {by_e[31], by_e};
			dd_s1[3] <= {cx_e[31], cx_e} - {bx_e[31], bx_e};
			dd_s1[4] <= {ax_e[31], ax_e} - {cx_e[31], cx_e};
			dd_s1[5] <= {bx_e[31], bx_e} - {ax_e[31], ax_e};

			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			p_s2[0] <= ax_s1 * dd_s1[0];
			p_s2[1] <= bx_s1 * dd_s1[1];
			p_s2[2] <= cx_s1 * dd_s1[2];
			sq_s2[0] <= ax_s1 * ax_s1;
			sq_s2[1] <= ay_s1 * ay_s1;
			sq_s2[2] <= bx_s1 * bx_s1;
			sq_s2[3] <= by_s1 * by_s1;
			sq_s2[4] <= cx_s1 * cx_s1;
			sq_s2[5] <= cy_s1 * cy_s1;
			dd_s2 <= dd_s1;

			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			det_s3 <= (DEN_W'(p_s2[0]) + DEN_W'(p_s2[1]) + DEN_W'(p_s2[2])) <<< 1;
			s_s3[0] <= sq_s2[0] + sq_s2[1];
			s_s3[1] <= sq_s2[2] + sq_s2[3];
			s_s3[2] <= sq_s2[4] + sq_s2[5];
			dd_s3 <= dd_s2;

			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			dneg_s4 <= det_s3[DEN_W-1];
			dabs_s4 <= det_s3[DEN_W-1] ? DEN_W'(-det_s3) : DEN_W'(det_s3);
			for (int i = 0; i < 6; i++) begin
				plo_s4[i] <= $signed({1'b0, s_s3[i % 3][31:0]}) * dd_s3[i];
				phi_s4[i] <= $signed({1'b0, s_s3[i % 3][63:32]}) * dd_s3[i];
			end

			ax_s5 <= ax_s4;
			ay_s5 <= ay_s4;
			dabs_s5 <= dabs_s4;
			dneg_s5 <= dneg_s4;
			coll_s5 <= dabs_s4 <= thr_sh;
			dsh_s5 <= REM_W'(dabs_s4) << (COORD_WIDTH - 1);
			dshp_s5 <= (REM_W'(dabs_s4) << (COORD_WIDTH - 1)) + REM_W'(dabs_s4);
			for (int i = 0; i < 6; i++) begin
				t_s5[i] <= (NUM_W'(phi_s4[i]) <<< 32) + NUM_W'(plo_s4[i]);
			end

			ax_s6 <= ax_s5;
			ay_s6 <= ay_s5;
			dabs_s6 <= dabs_s5;
			dneg_s6 <= dneg_s5;
			coll_s6 <= coll_s5;
			dsh_s6 <= dsh_s5;
			dshp_s6 <= dshp_s5;
			nx_s6 <= t_s5[0] + t_s5[1] + t_s5[2];
			ny_s6 <= t_s5[3] + t_s5[4] + t_s5[5];

			ax_s7 <= ax_s6;
			ay_s7 <= ay_s6;
			dabs_s7 <= dabs_s6;
			coll_s7 <= coll_s6;
			dsh_s7 <= dsh_s6;
			dshp_s7 <= dshp_s6;
			negx_s7 <= nx_s6[NUM_W-1] ^ dneg_s6;
			negy_s7 <= ny_s6[NUM_W-1] ^ dneg_s6;
			nxa_s7 <= nx_s6[NUM_W-1] ? NUM_W'(-nx_s6) : NUM_W'(nx_s6);
			nya_s7 <= ny_s6[NUM_W-1] ? NUM_W'(-ny_s6) : NUM_W'(ny_s6);

			dst.ax <= ax_s7;
			dst.ay <= ay_s7;
			dst.d_abs <= dabs_s7;
			dst.coll <= coll_s7;
			dst.neg_x <= negx_s7;
			dst.neg_y <= negy_s7;
			dst.nx_abs <= nxa_s7;
			dst.ny_abs <= nya_s7;
			dst.ovf_x <= REM_W'(nxa_s7) >= (negx_s7 ? dshp_s7 : dsh_s7);
			dst.ovf_y <= REM_W'(nya_s7) >= (negy_s7 ? dshp_s7 : dsh_s7);
		end
	end

	assign dst_valid = v_s8;

endmodule
`default_nettype wire

// File: rtl/circ_div.sv
`default_nettype none
module circ_div #(
	parameter int QBITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               src_valid,
	input  circ_pkg::div_in_t  src,
	output logic               dst_valid,
	output circ_pkg::div_out_t dst
);
	import circ_pkg::*;

	logic             v_s  [0:QBITS];
	div_in_t          st_s [0:QBITS];
	logic [REM_W-1:0] rx_s [0:QBITS];
	logic [REM_W-1:0] ry_s [0:QBITS];
	logic [31:0]      qx_s [0:QBITS];
	logic [31:0]      qy_s [0:QBITS];

	assign v_s[0]  = src_valid;
	assign st_s[0] = src;
	assign rx_s[0] = REM_W'(src.nx_abs);
	assign ry_s[0] = REM_W'(src.ny_abs);
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int B = QBITS - 1 - k;
		logic [REM_W-1:0] dsh;
		logic [REM_W:0]   subx, suby;

		assign dsh  = REM_W'(st_s[k].d_abs) << B;
		assign subx = {1'b0, rx_s[k]} - {1'b0, dsh};
		assign suby = {1'b0, ry_s[k]} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1] <= st_s[k];
				rx_s[k+1] <= subx[REM_W] ? rx_s[k] : subx[REM_W-1:0];
				ry_s[k+1] <= suby[REM_W] ? ry_s[k] : suby[REM_W-1:0];
				qx_s[k+1] <= qx_s[k] | (subx[REM_W] ? 32'd0 : (32'd1 << B));
				qy_s[k+1] <= qy_s[k] | (suby[REM_W] ? 32'd0 : (32'd1 << B));
			end
		end
	end

	assign dst_valid = v_s[QBITS];

	always_comb begin
		dst.qx    = qx_s[QBITS];
		dst.qy    = qy_s[QBITS];
		dst.neg_x = st_s[QBITS].neg_x;
		dst.neg_y = st_s[QBITS].neg_y;
		dst.ovf_x = st_s[QBITS].ovf_x;
		dst.ovf_y = st_s[QBITS].ovf_y;
		dst.coll  = st_s[QBITS].coll;
		dst.ax    = st_s[QBITS].ax;
		dst.ay    = st_s[QBITS].ay;
	end

endmodule
`default_nettype wire

// File: rtl/circ_sqrt.sv
`default_nettype none
module circ_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        src_valid,
	input  logic [circ_pkg::SRAD_W-1:0] src_val,
	input  circ_pkg::sq_tag_t           src_tag,
	output logic                        dst_valid,
	output logic [circ_pkg::ROOT_W-1:0] dst_root,
	output circ_pkg::sq_tag_t           dst_tag
);
	import circ_pkg::*;

	logic              v_s    [0:ROOT_W];
	sq_tag_t           tag_s  [0:ROOT_W];
	logic [SRAD_W-1:0] val_s  [0:ROOT_W];
	logic [SREM_W-1:0] rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];

	assign v_s[0]    = src_valid;
	assign tag_s[0]  = src_tag;
	assign val_s[0]  = src_val;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [SREM_W-1:0] rem_n, trial;
		logic              ge;

		assign rem_n = {rem_s[k][SREM_W-3:0], val_s[k][SRAD_W-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1]  <= tag_s[k];
				val_s[k+1]  <= val_s[k] << 2;
				rem_s[k+1]  <= ge ? rem_n - trial : rem_n;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			end
		end
	end

	assign dst_valid = v_s[ROOT_W];
	assign dst_root  = root_s[ROOT_W];
	assign dst_tag   = tag_s[ROOT_W];

endmodule
`default_nettype wire

// File: rtl/circumcircle_three_points_unit.sv
// Circumcircle of three points, fully pipelined.
// Pipeline from input transfer to result, in order:
// 8 front stages, one divider stage per quotient bit, 4 distance stages,
// 32 square-root stages and the output register.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset (arst_n low, asynchronous): pipeline empty, threshold register 0.
`default_nettype none
module circumcircle_three_points_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pts_valid,
	output logic           pts_stall,
	input  circ_pkg::pts_t pts,
	output logic           circ_valid,
	input  logic           circ_stall,
	output circ_pkg::circ_t circ,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_data
);
	import circ_pkg::*;

	localparam logic [32:0] LIM_POS = 33'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic [32:0] LIM_NEG = 33'(64'd1 << (COORD_WIDTH - 1));
	localparam logic [31:0] RAD_MAX = 32'((64'd1 << COORD_WIDTH) - 64'd1);

	logic        en;
	logic [31:0] thr_q;

	logic     fr_valid, dv_valid;
	div_in_t  fr_data;
	div_out_t dv_data;

	logic               v_p1, v_p2, v_p3, v_p4;
	logic signed [31:0] ax_p1, ay_p1, ox_p1, oy_p1;
	logic               coll_p1, sat_p1;
	logic signed [31:0] ox_p2, oy_p2;
	logic signed [32:0] dx_p2, dy_p2;
	logic               coll_p2, sat_p2;
	logic signed [31:0] ox_p3, oy_p3;
	logic signed [65:0] dx2_p3, dy2_p3;
	logic               coll_p3, sat_p3;
	logic [SRAD_W-1:0]  val_p4;
	sq_tag_t            tag_p4;

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sq_tag_t           sq_tag;

	logic [32:0] qx_sel, qy_sel, ox_w, oy_w;
	logic [65:0] d2;
	logic [31:0] rad;
	circ_t       res;

	assign en        = !(circ_valid && circ_stall);
	assign pts_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	circ_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(pts_valid),
		.src      (pts),
		.thr      (thr_q),
		.dst_valid(fr_valid),
		.dst      (fr_data)
	);

	circ_div #(
		.QBITS(COORD_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(fr_valid),
		.src      (fr_data),
		.dst_valid(dv_valid),
		.dst      (dv_data)
	);

	always_comb begin
		qx_sel = dv_data.ovf_x ? (dv_data.neg_x ? LIM_NEG : LIM_POS) : {1'b0, dv_data.qx};
		qy_sel = dv_data.ovf_y ? (dv_data.neg_y ? LIM_NEG : LIM_POS) : {1'b0, dv_data.qy};
		ox_w   = dv_data.neg_x ? -qx_sel : qx_sel;
		oy_w   = dv_data.neg_y ? -qy_sel : qy_sel;
		d2     = dx2_p3 + dy2_p3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1       <= 1'b0;
			v_p2       <= 1'b0;
			v_p3       <= 1'b0;
			v_p4       <= 1'b0;
			circ_valid <= 1'b0;
		end else if (en) begin
			v_p1       <= dv_valid;
			v_p2       <= v_p1;
			v_p3       <= v_p2;
			v_p4       <= v_p3;
			circ_valid <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_p1   <= dv_data.ax;
			ay_p1   <= dv_data.ay;
			ox_p1   <= ox_w[31:0];
			oy_p1   <= oy_w[31:0];
			coll_p1 <= dv_data.coll;
			sat_p1  <= dv_data.ovf_x || dv_data.ovf_y;

			ox_p2   <= ox_p1;
			oy_p2   <= oy_p1;
			dx_p2   <= {ax_p1[31], ax_p1} - {ox_p1[31], ox_p1};
			dy_p2   <= {ay_p1[31], ay_p1} - {oy_p1[31], oy_p1};
			coll_p2 <= coll_p1;
			sat_p2  <= sat_p1;

			ox_p3   <= ox_p2;
			oy_p3   <= oy_p2;
			dx2_p3  <= dx_p2 * dx_p2;
			dy2_p3  <= dy_p2 * dy_p2;
			coll_p3 <= coll_p2;
			sat_p3  <= sat_p2;

			val_p4      <= d2[SRAD_W-1:0];
			tag_p4.ox   <= ox_p3;
			tag_p4.oy   <= oy_p3;
			tag_p4.coll <= coll_p3;
			tag_p4.sat  <= sat_p3;
			tag_p4.big  <= |d2[65:SRAD_W];

			circ <= res;
		end
	end

	circ_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(v_p4),
		.src_val  (val_p4),
		.src_tag  (tag_p4),
		.dst_valid(sq_valid),
		.dst_root (sq_root),
		.dst_tag  (sq_tag)
	);

	always_comb begin
		rad = (sq_tag.big || sq_root > RAD_MAX) ? RAD_MAX : sq_root;
		if (sq_tag.coll || rad == 32'd0) begin
			res.center_x = '0;
			res.center_y = '0;
			res.radius   = '0;
			res.status   = STATUS_DEGEN;
		end else begin
			res.center_x = sq_tag.ox;
			res.center_y = sq_tag.oy;
			res.radius   = rad;
			res.status   = sq_tag.sat ? STATUS_SAT : STATUS_OK;
		end
	end

endmodule
`default_nettype wire

// File: rtl/circ_chk.sv
`default_nettype none
module circ_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            pts_valid,
	input wire logic            pts_stall,
	input wire circ_pkg::pts_t  pts,
	input wire logic            circ_valid,
	input wire logic            circ_stall,
	input wire circ_pkg::circ_t circ,
	input wire logic            cfg_valid,
	input wire logic            cfg_ready,
	input wire logic [31:0]     cfg_data
);
	import circ_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ_stall |=> circ_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ_stall |=> $stable(circ))
		else $error("result changed while stalled");

	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ_stall |-> pts_stall)
		else $error("input taken while output held");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid |-> (circ.status == STATUS_OK || circ.status == STATUS_DEGEN ||
			circ.status == STATUS_SAT))
		else $error("bad status code");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ.status == STATUS_DEGEN |->
			circ.center_x == 32'sd0 && circ.center_y == 32'sd0 && circ.radius == 32'd0)
		else $error("degenerate result not cleared");

endmodule

bind circumcircle_three_points_unit circ_chk u_circ_chk (.*);
`default_nettype wire
